FILE: rtl/spfa_pkg.sv
`default_nettype none

package spfa_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned ENTRY_W    = 10;
  localparam int unsigned CHANGED_W  = 11;
  localparam int unsigned OUT_FRAME_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CURSOR_W   = 21;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_EXPAND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEANUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 2'd2;

  localparam logic [ADDR_W-1:0] STACK_BASE_RESET = 32'h0040_0000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  fault_address;
    logic [ENTRY_W-1:0] entry_index;
  } spfa_req_t;

  typedef struct packed {
    logic                   status;
    logic [CHANGED_W-1:0]   pages_changed;
    logic                   entry_present;
    logic [OUT_FRAME_W-1:0] entry_frame;
  } spfa_rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXP_START,
    S_EXP_CHK,
    S_EXP_POP,
    S_CLN_START,
    S_CLN_CHK,
    S_FIN
  } spfa_state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_DEC,
    IDX_INC,
    IDX_ZERO,
    IDX_ENTRY
  } spfa_idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_BUMP,
    WR_POP
  } spfa_wr_op_t;

  typedef struct packed {
    logic         capture;
    spfa_idx_op_t idx_op;
    spfa_wr_op_t  tbl_wr;
    logic         fs_push;
    logic         fs_pop;
    logic         bump;
    logic         cnt_inc;
    logic         set_oom;
    logic         load_rsp;
  } spfa_cmd_t;

  typedef struct packed {
    logic entry_present;
    logic at_target;
    logic at_last;
    logic target_ok;
    logic fs_empty;
    logic pool_avail;
    logic rsp_free;
  } spfa_status_t;

endpackage

`default_nettype wire

FILE: rtl/spfa_ram.sv
`default_nettype none

module spfa_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/spfa_ctrl.sv
`default_nettype none

module spfa_ctrl
  import spfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [MODE_W-1:0] req_mode,
  output logic                   req_stall,
  input  wire spfa_status_t      sts,
  output spfa_cmd_t              cmd
);

  spfa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.idx_op = IDX_HOLD;
    cmd.tbl_wr = WR_NONE;
    req_stall  = (state != S_IDLE);

    case (state)
      S_INIT: begin
        // clearing pass, one entry per cycle
        cmd.tbl_wr = WR_CLEAR;
        cmd.idx_op = IDX_INC;
        if (sts.at_last) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (req_mode)
            MODE_EXPAND:  state_next = S_EXP_START;
            MODE_CLEANUP: state_next = S_CLN_START;
            MODE_READ: begin
              cmd.idx_op = IDX_ENTRY;
              state_next = S_FIN;
            end
            default:      state_next = S_FIN;
          endcase
        end
      end

      S_EXP_START: begin
        if (sts.target_ok) begin
          cmd.idx_op = IDX_TOP;
          state_next = S_EXP_CHK;
        end else begin
          state_next = S_FIN;
        end
      end

      S_EXP_CHK: begin
        if (sts.entry_present) begin
          if (sts.at_target) begin
            state_next = S_FIN;
          end else begin
            cmd.idx_op = IDX_DEC;
          end
        end else if (!sts.fs_empty) begin
          cmd.fs_pop = 1'b1;
          state_next = S_EXP_POP;
        end else if (sts.pool_avail) begin
          cmd.tbl_wr  = WR_BUMP;
          cmd.bump    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.at_target) begin
            state_next = S_FIN;
          end else begin
            cmd.idx_op = IDX_DEC;
          end
        end else begin
          cmd.set_oom = 1'b1;
          state_next  = S_FIN;
        end
      end

      S_EXP_POP: begin
        cmd.tbl_wr  = WR_POP;
        cmd.cnt_inc = 1'b1;
        if (sts.at_target) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = S_EXP_CHK;
        end
      end

      S_CLN_START: begin
        cmd.idx_op = IDX_ZERO;
        state_next = S_CLN_CHK;
      end

      S_CLN_CHK: begin
        cmd.tbl_wr = WR_CLEAR;
        if (sts.entry_present) begin
          cmd.fs_push = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
        if (sts.at_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end

      S_FIN: begin
        if (sts.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/spfa_dp.sv
`default_nettype none

module spfa_dp
  import spfa_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned PAGE_SHIFT    = 12,
  parameter int unsigned FRAME_BITS    = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire spfa_req_t             req,
  output spfa_rsp_t                  rsp,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire spfa_cmd_t             cmd,
  output spfa_status_t               sts
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  // configuration
  logic [CURSOR_W-1:0] pool_limit;
  logic [ADDR_W-1:0]   stack_base;
  logic [CURSOR_W-1:0] cursor;

  // walk state
  logic [IDX_W-1:0]     idx, idx_next;
  logic [IDX_W-1:0]     target;
  logic                 target_ok;
  logic                 entry_ok;
  logic [MODE_W-1:0]    mode;
  logic [CHANGED_W-1:0] changed;
  logic                 oom;
  logic [CNT_W-1:0]     fcount;

  logic [ADDR_W-1:0] tgt_full;

  logic [FRAME_BITS:0]   tbl_rd_data, tbl_wr_data;
  logic                  tbl_wr_en;
  logic [FRAME_BITS-1:0] fs_rd_data;
  logic                  fs_wr_en;
  logic [IDX_W-1:0]      fs_rd_addr;

  assign tgt_full = (req.fault_address - stack_base) >> PAGE_SHIFT;

  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:  idx_next = idx;
      IDX_TOP:   idx_next = IDX_LAST;
      IDX_DEC:   idx_next = idx - 1'b1;
      IDX_INC:   idx_next = idx + 1'b1;
      IDX_ZERO:  idx_next = '0;
      IDX_ENTRY: idx_next = IDX_W'(req.entry_index);
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= '0;
      stack_base <= STACK_BASE_RESET;
      cursor     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POOL_FIRST: cursor     <= CURSOR_W'(cfg_data[OUT_FRAME_W-1:0]);
          CFG_POOL_END:   pool_limit <= cfg_data[CURSOR_W-1:0];
          CFG_STACK_BASE: stack_base <= cfg_data;
          default: ;
        endcase
      end else if (cmd.bump) begin
        cursor <= cursor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else if (cmd.fs_pop) begin
      fcount <= fcount - 1'b1;
    end else if (fs_wr_en) begin
      fcount <= fcount + 1'b1;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode      <= req.mode;
      target    <= IDX_W'(tgt_full);
      target_ok <= tgt_full < ADDR_W'(TABLE_ENTRIES);
      entry_ok  <= ADDR_W'(req.entry_index) < ADDR_W'(TABLE_ENTRIES);
      changed   <= '0;
      oom       <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        changed <= changed + 1'b1;
      end
      if (cmd.set_oom) begin
        oom <= 1'b1;
      end
    end
  end

  // table of {present, frame}
  always_comb begin
    case (cmd.tbl_wr)
      WR_CLEAR: tbl_wr_data = '0;
      WR_BUMP:  tbl_wr_data = {1'b1, FRAME_BITS'(cursor)};
      WR_POP:   tbl_wr_data = {1'b1, fs_rd_data};
      default:  tbl_wr_data = '0;
    endcase
  end

  assign tbl_wr_en = (cmd.tbl_wr != WR_NONE);

  spfa_ram #(
    .WIDTH (FRAME_BITS + 1),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (idx),
    .wr_data (tbl_wr_data),
    .rd_addr (idx_next),
    .rd_data (tbl_rd_data)
  );

  // free stack, top at fcount-1
  assign fs_wr_en   = cmd.fs_push && (fcount != CNT_FULL);
  assign fs_rd_addr = IDX_W'(fcount - 1'b1);

  spfa_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_free_stack (
    .clk     (clk),
    .wr_en   (fs_wr_en),
    .wr_addr (IDX_W'(fcount)),
    .wr_data (tbl_rd_data[FRAME_BITS-1:0]),
    .rd_addr (fs_rd_addr),
    .rd_data (fs_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.status        <= oom;
      rsp.pages_changed <= changed;
      if ((mode == MODE_READ) && entry_ok && tbl_rd_data[FRAME_BITS]) begin
        rsp.entry_present <= 1'b1;
        rsp.entry_frame   <= OUT_FRAME_W'(tbl_rd_data[FRAME_BITS-1:0]);
      end else begin
        rsp.entry_present <= 1'b0;
        rsp.entry_frame   <= '0;
      end
    end
  end

  always_comb begin
    sts.entry_present = tbl_rd_data[FRAME_BITS];
    sts.at_target     = (idx == target);
    sts.at_last       = (idx == IDX_LAST);
    sts.target_ok     = target_ok;
    sts.fs_empty      = (fcount == '0);
    sts.pool_avail    = (cursor < pool_limit);
    sts.rsp_free      = !rsp_valid || !rsp_stall;
  end

`ifndef SYNTHESIS
  a_fcount_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= CNT_FULL)
    else $error("free stack count past table size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.fs_pop |-> (fcount != '0) && !fs_wr_en)
    else $error("pop from empty free stack");

  a_bump_in_pool: assert property (@(posedge clk) disable iff (rst)
    cmd.bump |-> (cursor < pool_limit) && (cmd.tbl_wr == WR_BUMP))
    else $error("bump past pool end");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |=> rsp_valid && $past(!rsp_valid || !rsp_stall))
    else $error("result overwritten while held");
`endif

endmodule

`default_nettype wire

FILE: rtl/stack_page_table_frame_allocator_unit.sv
`default_nettype none

// Channel   Direction  Handshake                 Item
// req       in         req_valid / req_stall     spfa_req_t  (mode, fault_address, entry_index)
// rsp       out        rsp_valid / rsp_stall     spfa_rsp_t  (status, pages_changed, present, frame)
// cfg       in         cfg_valid / cfg_ready     cfg_index + cfg_data, always ready
//
// One item at a time. Expand walks the table one entry a cycle, except that an entry
// whose frame comes off the free stack takes an extra pop state; cleanup walks every
// entry; the walk is bound by the single-port read of the table RAM.
// After rst the table is swept clear, one entry a cycle, with req_stall high;
// configuration writes are taken throughout.
// A finished result sits in the output register while the next item is taken.

module stack_page_table_frame_allocator_unit
  import spfa_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned PAGE_SHIFT    = 12,
  parameter int unsigned FRAME_BITS    = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire spfa_req_t             req,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output spfa_rsp_t                  rsp,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  spfa_cmd_t    cmd;
  spfa_status_t sts;

  // registers are plain flops, a write never waits
  assign cfg_ready = 1'b1;

  // Sequencer: clearing sweep, expand walk (top entry down to the target
  // page), cleanup walk (entry zero up), read, then result hand-off.
  spfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: table and free-stack RAMs, bump cursor, config registers,
  // walk index and result register.
  spfa_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT),
    .FRAME_BITS    (FRAME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: tb/spfa_result_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and configuration channels of the stack page
// table unit. Keeps its own copy of the table and of the frame allocator,
// works out the result of every accepted item, and compares results in order.
module spfa_result_checker
  import spfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  spfa_req_t             req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  spfa_rsp_t             rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatch_count,
  output int unsigned           results_owed
);

  localparam int unsigned TBL       = 1024;
  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned FRAME_W   = 20;

  // page table copy
  bit                 present_q [TBL];
  logic [FRAME_W-1:0] frame_of  [TBL];
  // allocator copy
  logic [FRAME_W-1:0] freed     [TBL];
  int unsigned        freed_cnt;
  logic [CURSOR_W-1:0] cursor;
  // registers
  logic [CURSOR_W-1:0] pool_stop;
  logic [ADDR_W-1:0]   region_base;

  spfa_rsp_t pending_outcomes [$];

  // free stack first, then the bump cursor
  function automatic bit grab_frame(output logic [FRAME_W-1:0] f);
    if (freed_cnt > 0) begin
      freed_cnt--;
      f = freed[freed_cnt];
      return 1'b1;
    end
    if (cursor < pool_stop) begin
      f = cursor[FRAME_W-1:0];
      cursor = cursor + 1'b1;
      return 1'b1;
    end
    f = '0;
    return 1'b0;
  endfunction

  function automatic spfa_rsp_t run_table_op(input spfa_req_t it);
    spfa_rsp_t          r;
    logic [ADDR_W-1:0]  target;
    logic [ADDR_W-1:0]  i;
    logic [FRAME_W-1:0] f;
    int unsigned        changed;
    r = '0;
    changed = 0;
    case (it.mode)
      MODE_EXPAND: begin
        target = (it.fault_address - region_base) >> PAGE_BITS;
        i = TBL;
        while (i > target) begin
          i = i - 1;
          if (!present_q[i]) begin
            if (!grab_frame(f)) begin
              r.status = 1'b1;
              break;
            end
            frame_of[i] = f;
            present_q[i] = 1'b1;
            changed++;
          end
        end
      end
      MODE_CLEANUP: begin
        for (int unsigned k = 0; k < TBL; k++) begin
          if (present_q[k]) begin
            if (freed_cnt < TBL) begin
              freed[freed_cnt] = frame_of[k];
              freed_cnt++;
            end
            present_q[k] = 1'b0;
            changed++;
          end
        end
      end
      MODE_READ: begin
        if (it.entry_index < TBL && present_q[it.entry_index]) begin
          r.entry_present = 1'b1;
          r.entry_frame = frame_of[it.entry_index];
        end
      end
      default: ;
    endcase
    r.pages_changed = changed[CHANGED_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    spfa_rsp_t want;
    bit        bad;
    if (rst) begin
      for (int unsigned k = 0; k < TBL; k++) present_q[k] = 1'b0;
      freed_cnt = 0;
      pool_stop = '0;
      region_base = STACK_BASE_RESET;
      cursor = '0;
      mismatch_count = 0;
      pending_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POOL_FIRST: cursor = {1'b0, cfg_data[FRAME_W-1:0]};
          CFG_POOL_END:   pool_stop = cfg_data[CURSOR_W-1:0];
          CFG_STACK_BASE: region_base = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) pending_outcomes.push_back(run_table_op(req));
      if (rsp_valid && !rsp_stall) begin
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result at %0t: status %0d pages %0d present %0d frame %05h",
                     $realtime, rsp.status, rsp.pages_changed, rsp.entry_present,
                     rsp.entry_frame);
        end else begin
          want = pending_outcomes.pop_front();
          bad = (rsp.status !== want.status) || (rsp.pages_changed !== want.pages_changed) ||
                (rsp.entry_present !== want.entry_present) ||
                (rsp.entry_frame !== want.entry_frame);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at %0t: expected status %0d pages %0d present %0d frame %05h",
                       $realtime, want.status, want.pages_changed, want.entry_present,
                       want.entry_frame, "; got status %0d pages %0d present %0d frame %05h",
                       rsp.status, rsp.pages_changed, rsp.entry_present, rsp.entry_frame);
          end
        end
      end
    end
    results_owed <= pending_outcomes.size();
  end

endmodule

FILE: tb/stack_page_table_frame_allocator_unit_tb.sv
`timescale 1ns / 100ps

module stack_page_table_frame_allocator_unit_tb;
  import spfa_pkg::*;

  // mode 3 has no operation behind it; the block must answer with all zeros
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 87;
  // receiver hold-off, long enough to cover a full table walk plus a queued item
  localparam int unsigned HOLD_CYCLES     = 2500;
  localparam int unsigned TAIL_CYCLES     = 16;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  spfa_req_t             req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  spfa_rsp_t             rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned results_owed;

  int unsigned       burst_left;
  logic [ADDR_W-1:0] cur_base;
  bit                long_hold_go;

  stack_page_table_frame_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spfa_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. Worst case is every item a full 1024-entry walk fed from the
  // free stack behind the heaviest stall pattern; this allows several times that.
  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side back-pressure. Stretches of no stall, light random stall and
  // heavy stall, plus one long hold-off once the random part has begun so the
  // block fills up and has to stall the request side.
  initial begin : rsp_backpressure
    int unsigned style;
    int unsigned span;
    bit          hold_done;
    rsp_stall = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_go && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      style = $urandom_range(0, 2);
      span = $urandom_range(20, 150);
      repeat (span) begin
        case (style)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 99) < 35);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic spfa_req_t make_req(input logic [MODE_W-1:0] m,
                                         input logic [ADDR_W-1:0] a,
                                         input logic [ENTRY_W-1:0] e);
    spfa_req_t it;
    it.mode = m;
    it.fault_address = a;
    it.entry_index = e;
    return it;
  endfunction

  // Random item. Expands mostly aim at the top of the table so walks stay
  // short and the table fills over several items; a few aim anywhere in the table,
  // land past the top or use a fully random address.
  function automatic spfa_req_t random_request(input logic [ADDR_W-1:0] base);
    spfa_req_t         it;
    int unsigned       pick;
    int unsigned       shape;
    logic [ADDR_W-1:0] page;
    it.fault_address = $urandom;
    it.entry_index = ENTRY_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.mode = MODE_EXPAND;
      shape = $urandom_range(0, 99);
      if (shape < 70) page = $urandom_range(960, 1023);
      else if (shape < 88) page = $urandom_range(640, 1023);
      else if (shape < 94) page = $urandom_range(0, 1023);
      else page = $urandom_range(1024, 20'hF_FFFF);
      if (shape < 97) it.fault_address = base + (page << 12) + $urandom_range(0, 4095);
    end else if (pick < 65) begin
      it.mode = MODE_CLEANUP;
    end else if (pick < 94) begin
      it.mode = MODE_READ;
      // bias reads toward the top, where entries tend to be present
      if ($urandom_range(0, 99) < 70) it.entry_index = ENTRY_W'($urandom_range(896, 1023));
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // Offer one item; the sender runs in bursts with random gaps in between.
  // Valid stays high from one item of a burst to the next.
  task automatic offer_item(input spfa_req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Wait until every result owed has come back; the block is idle then.
  task automatic drain;
    req_valid <= 1'b0;
    burst_left = 0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // All three registers back to back; only valid is lowered afterwards.
  task automatic load_settings(input logic [19:0] first, input logic [20:0] stop,
                               input logic [ADDR_W-1:0] base);
    write_reg(CFG_POOL_FIRST, {12'd0, first});
    write_reg(CFG_POOL_END, {11'd0, stop});
    write_reg(CFG_STACK_BASE, base);
    cfg_valid <= 1'b0;
    cur_base = base;
  endtask

  task automatic random_phase(input logic [19:0] first, input logic [20:0] stop,
                              input logic [ADDR_W-1:0] base);
    load_settings(first, stop, base);
    repeat (ITEMS_PER_PHASE) offer_item(random_request(cur_base));
    drain();
  endtask

  initial begin : stimulus
    logic [19:0] rand_first;
    logic [20:0] rand_stop;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POOL_FIRST;
    cfg_data = '0;
    burst_left = 0;
    cur_base = STACK_BASE_RESET;
    long_hold_go = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed: reset settings, pool is empty ---
    offer_item(make_req(MODE_EXPAND, STACK_BASE_RESET, '0));      // out of frames at once
    offer_item(make_req(MODE_UNUSED, '1, '1));                    // unused mode, all ones
    offer_item(make_req(MODE_READ, '0, 10'd1023));                // absent entry
    offer_item(make_req(MODE_READ, '1, 10'd0));
    drain();

    // --- directed: six frames at the very top of the frame range, high base ---
    load_settings(20'hF_FFFA, 21'h10_0000, 32'hFFFF_F000);
    offer_item(make_req(MODE_EXPAND, 32'h003F_BFFF, '0));   // page 1020, address wraps: 4
    offer_item(make_req(MODE_EXPAND, 32'h003F_1000, '0));   // page 1010: 2 then out of frames
    offer_item(make_req(MODE_READ, '0, 10'd1018));          // last frame handed out
    offer_item(make_req(MODE_READ, '0, 10'd1017));          // left absent by the failed walk
    offer_item(make_req(MODE_EXPAND, 32'hFFFF_E000, '0));   // below base: past the top
    offer_item(make_req(MODE_EXPAND, 32'hFFFF_FFFF, '0));   // page 0: nothing left, stops at 1017
    offer_item(make_req(MODE_CLEANUP, '0, '0));             // frees six
    offer_item(make_req(MODE_EXPAND, 32'h003F_D000, '0));   // reuses freed frames, last in first
    offer_item(make_req(MODE_READ, '0, 10'd1023));
    offer_item(make_req(MODE_READ, '0, 10'd1022));
    offer_item(make_req(MODE_CLEANUP, '1, '1));
    offer_item(make_req(MODE_CLEANUP, '0, '0));             // empty table frees nothing
    drain();

    // --- random phases over a spread of pool and base settings ---
    random_phase(20'h0_0010, 21'h00_0040, 32'h0040_0000);   // tiny pool, frequent exhaustion
    random_phase(20'h0_0000, 21'h00_0000, 32'hFFFF_FFFF);   // no pool, recycled frames only
    random_phase(20'h1_2345, 21'h01_2340, $urandom & 32'hFFFF_F000); // end below first

    long_hold_go = 1'b1;
    rand_first = 20'($urandom_range(0, 20'hF_FFFF));
    rand_stop = 21'(rand_first + $urandom_range(0, 3000));
    if (rand_stop > 21'h10_0000) rand_stop = 21'h10_0000;
    random_phase(rand_first, rand_stop, $urandom);

    random_phase(20'hF_FF00, 21'h10_0000, 32'h0000_0000);   // top of the frame range
    random_phase(20'h0_0000, 21'h10_0000, 32'h7FFF_F000);   // widest pool

    // --- directed: fill the whole table from an empty one ---
    load_settings(20'h0_0000, 21'h10_0000, 32'h0000_0000);
    offer_item(make_req(MODE_CLEANUP, '0, '0));
    offer_item(make_req(MODE_EXPAND, '0, '0));              // 1024 pages
    offer_item(make_req(MODE_READ, '0, 10'd0));
    offer_item(make_req(MODE_READ, '1, 10'd1023));
    offer_item(make_req(MODE_READ, '0, 10'd512));
    offer_item(make_req(MODE_CLEANUP, '0, '0));             // 1024 freed
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: stack_page_table_frame_allocator_unit.f
rtl/spfa_pkg.sv
rtl/spfa_ram.sv
rtl/spfa_ctrl.sv
rtl/spfa_dp.sv
rtl/stack_page_table_frame_allocator_unit.sv
tb/spfa_result_checker.sv
tb/stack_page_table_frame_allocator_unit_tb.sv
